// ===== hw/rtl/ddgp_pkg.sv =====
// Shared types and constants for the go-to-point wheel speed controller.
// Used by the CORDIC cells, the post-processing stages and the top level.
`default_nettype none
package ddgp_pkg;

    localparam int unsigned XY_W   = 23;   // CORDIC x/y, offsets times 2^8
    localparam int unsigned Z_W    = 27;   // CORDIC angle, degrees times 2^16
    localparam int unsigned KINV   = 39797;
    localparam int unsigned ATAN_N = 24;

    typedef struct packed {
        logic              valid;
        logic              mode;
        logic [3:0]        idx;
        logic signed [8:0] rh;
        logic signed [8:0] th;
        logic              zero;
    } meta_t;

    typedef struct packed {
        meta_t                   meta;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
    } cordic_t;

    typedef enum logic [1:0] {
        REG_DIST_GAIN  = 2'd0,
        REG_HEAD_GAIN  = 2'd1,
        REG_TURN_GAIN  = 2'd2,
        REG_SPEED_LIM  = 2'd3
    } reg_index_t;

    // atan(2^-i) in degrees times 2^16
    function automatic logic [21:0] atan_q16(input int unsigned i);
        logic [21:0] r;
        case (i)
            0: r = 22'd2949120;  1: r = 22'd1740967;  2: r = 22'd919879;
            3: r = 22'd466945;   4: r = 22'd234379;   5: r = 22'd117304;
            6: r = 22'd58666;    7: r = 22'd29335;    8: r = 22'd14668;
            9: r = 22'd7334;    10: r = 22'd3667;    11: r = 22'd1833;
            12: r = 22'd917;    13: r = 22'd458;     14: r = 22'd229;
            15: r = 22'd115;    16: r = 22'd57;      17: r = 22'd29;
            18: r = 22'd14;     19: r = 22'd7;       20: r = 22'd4;
            21: r = 22'd2;      22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

    // bring an angle error into [-180, 180]; inputs stay within two turns
    function automatic logic signed [11:0] wrap_deg(input logic signed [11:0] e);
        logic signed [11:0] r;
        r = e;
        if (r > 12'sd180) r = r - 12'sd360;
        if (r > 12'sd180) r = r - 12'sd360;
        if (r < -12'sd180) r = r + 12'sd360;
        if (r < -12'sd180) r = r + 12'sd360;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ddgp_cell.sv =====
// One vectoring CORDIC micro-rotation, registered, with the command sideband.
// Depends on ddgp_pkg.
`default_nettype none
module ddgp_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              en,
    input  ddgp_pkg::cordic_t cin,
    output ddgp_pkg::cordic_t cout
);
    localparam logic signed [ddgp_pkg::Z_W-1:0] ANG =
        ddgp_pkg::Z_W'(ddgp_pkg::atan_q16(IDX));

    ddgp_pkg::cordic_t c_reg, c_next;
    logic signed [ddgp_pkg::XY_W-1:0] xs, ys;

    always_comb begin
        xs = cin.x >>> IDX;
        ys = cin.y >>> IDX;
        c_next = cin;
        if (cin.y >= 0) begin
            c_next.x = cin.x + ys;
            c_next.y = cin.y - xs;
            c_next.z = cin.z + ANG;
        end else begin
            c_next.x = cin.x - ys;
            c_next.y = cin.y + xs;
            c_next.z = cin.z - ANG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.meta.valid <= 1'b0;
        end else if (en) begin
            c_reg.meta.valid <= c_next.meta.valid;
        end
        if (en) begin
            c_reg.meta.mode <= c_next.meta.mode;
            c_reg.meta.idx  <= c_next.meta.idx;
            c_reg.meta.rh   <= c_next.meta.rh;
            c_reg.meta.th   <= c_next.meta.th;
            c_reg.meta.zero <= c_next.meta.zero;
            c_reg.x         <= c_next.x;
            c_reg.y         <= c_next.y;
            c_reg.z         <= c_next.z;
        end
    end

    assign cout = c_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/ddgp_post.sv =====
// Distance scaling, heading error, gain products and saturation after the CORDIC.
// Depends on ddgp_pkg. Three register stages, the last one is the output.
`default_nettype none
module ddgp_post #(
    parameter int unsigned GAIN_FRAC_BITS = 8
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               en,
    input  ddgp_pkg::cordic_t cin,
    input  wire  [15:0]       dist_gain,
    input  wire  [15:0]       head_gain,
    input  wire  [15:0]       turn_gain,
    input  wire  [6:0]        speed_limit,
    output logic              out_valid,
    output logic [3:0]        out_idx,
    output logic [7:0]        out_left,
    output logic [7:0]        out_right,
    output logic              out_rev,
    output logic              out_clip
);
    localparam int unsigned SH = GAIN_FRAC_BITS + 8;

    // stage 1: distance and folded error
    logic [21:0]        xc;
    logic [37:0]        dprod;
    logic signed [10:0] bearing;
    logic signed [26:0] zneg;
    logic signed [11:0] err0, errw;
    logic signed [22:0] dist_next;
    logic signed [7:0]  err_next;
    logic               rev_next;

    logic               v1_reg, mode1_reg, rev1_reg;
    logic [3:0]         idx1_reg;
    logic signed [22:0] dist1_reg;
    logic signed [7:0]  err1_reg;

    always_comb begin
        xc    = (cin.x < 0) ? 22'd0 : cin.x[21:0];
        dprod = 38'(xc) * 38'(ddgp_pkg::KINV);
        zneg  = -cin.z;
        if (cin.z >= 0) bearing = 11'(cin.z >>> 16);
        else            bearing = -11'(zneg >>> 16);
        if (cin.meta.zero) bearing = 11'sd90;
        if (cin.meta.mode) err0 = 12'(cin.meta.th) - 12'(cin.meta.rh);
        else               err0 = 12'(bearing) - 12'(cin.meta.rh);
        errw     = ddgp_pkg::wrap_deg(err0);
        rev_next = 1'b0;
        if (errw < -12'sd90) begin
            errw = errw + 12'sd180;
            rev_next = ~cin.meta.mode;
        end else if (errw > 12'sd90) begin
            errw = errw - 12'sd180;
            rev_next = ~cin.meta.mode;
        end
        err_next  = errw[7:0];
        dist_next = cin.meta.zero ? 23'sd0 : $signed({1'b0, dprod[37:16]});
        if (rev_next) dist_next = -dist_next;
    end

    // stage 2: gain products
    logic               v2_reg, mode2_reg, rev2_reg;
    logic [3:0]         idx2_reg;
    logic signed [39:0] dterm2_reg, hterm2_reg, tterm2_reg;
    logic signed [39:0] dterm_next, hterm_next, tterm_next;

    always_comb begin
        dterm_next = 40'($signed({1'b0, dist_gain})) * 40'(dist1_reg);
        hterm_next = (40'($signed({1'b0, head_gain})) * 40'(err1_reg)) <<< 8;
        tterm_next = 40'($signed({1'b0, turn_gain})) * 40'(err1_reg);
    end

    // stage 3: truncate toward zero and saturate
    function automatic logic signed [39:0] trunc0(input logic signed [39:0] v,
                                                  input int unsigned s);
        logic signed [39:0] n;
        n = -v;
        if (v >= 0) return v >>> s;
        return -(n >>> s);
    endfunction

    logic signed [39:0] vl, vr, lim;
    logic signed [7:0]  l_next, r_next;
    logic               clip_next;

    always_comb begin
        if (mode2_reg) begin
            vl = trunc0(tterm2_reg, GAIN_FRAC_BITS);
            vr = -vl;
        end else begin
            vl = trunc0(dterm2_reg + hterm2_reg, SH);
            vr = trunc0(dterm2_reg - hterm2_reg, SH);
        end
        lim       = $signed({33'd0, speed_limit});
        clip_next = 1'b0;
        l_next    = vl[7:0];
        r_next    = vr[7:0];
        if (vl > lim) begin
            l_next = lim[7:0]; clip_next = 1'b1;
        end else if (vl < -lim) begin
            l_next = 8'(-lim); clip_next = 1'b1;
        end
        if (vr > lim) begin
            r_next = lim[7:0]; clip_next = 1'b1;
        end else if (vr < -lim) begin
            r_next = 8'(-lim); clip_next = 1'b1;
        end
    end

    logic       v3_reg, rev3_reg, clip3_reg;
    logic [3:0] idx3_reg;
    logic [7:0] l3_reg, r3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= cin.meta.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            mode1_reg  <= cin.meta.mode;
            rev1_reg   <= rev_next;
            idx1_reg   <= cin.meta.idx;
            dist1_reg  <= dist_next;
            err1_reg   <= err_next;
            mode2_reg  <= mode1_reg;
            rev2_reg   <= rev1_reg;
            idx2_reg   <= idx1_reg;
            dterm2_reg <= dterm_next;
            hterm2_reg <= hterm_next;
            tterm2_reg <= tterm_next;
            rev3_reg   <= rev2_reg;
            idx3_reg   <= idx2_reg;
            clip3_reg  <= clip_next;
            l3_reg     <= l_next;
            r3_reg     <= r_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_idx   = idx3_reg;
    assign out_left  = l3_reg;
    assign out_right = r3_reg;
    assign out_rev   = rev3_reg;
    assign out_clip  = clip3_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/diff_drive_goto_point.sv =====
// Wheel speed controller for a differential-drive robot: top level.
// Depends on ddgp_pkg, ddgp_cell and ddgp_post.
//
// Each request carries a pose and a target point (mode 0) or heading (mode 1)
// and yields one result with saturated left/right wheel speeds. The block is
// a pipeline: one input register, CORDIC_STAGES vectoring cells, then three
// post stages (distance scale, gain products, truncate/saturate into the
// output register). A new request is taken every cycle while the output is
// not stalled; the whole pipeline holds while a result waits on m_tready.
// Write the configuration registers only while idle.
`default_nettype none
module diff_drive_goto_point #(
    parameter int unsigned CORDIC_STAGES  = 16,
    parameter int unsigned GAIN_FRAC_BITS = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [3:0] robot_index, [14:4] robot_x, [25:15] robot_y, [34:26] robot_heading,
    // [45:35] target_x, [56:46] target_y, [65:57] target_heading, rest zero
    input  wire  [71:0] s_tdata,
    input  wire  [0:0]  s_tuser,    // [0] mode
    output logic        m_tvalid,
    input  wire         m_tready,
    // [3:0] robot_index_out, [11:4] left_speed, [19:12] right_speed, rest zero
    output logic [23:0] m_tdata,
    output logic [1:0]  m_tuser,    // [0] drives_reversed, [1] clipped
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    logic [15:0] dist_gain_reg, head_gain_reg, turn_gain_reg;
    logic [6:0]  speed_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_gain_reg   <= 16'd128;
            head_gain_reg   <= 16'd569;
            turn_gain_reg   <= 16'd171;
            speed_limit_reg <= 7'd127;
        end else if (cfg_valid) begin
            unique case (ddgp_pkg::reg_index_t'(cfg_index))
                ddgp_pkg::REG_DIST_GAIN: dist_gain_reg   <= cfg_data;
                ddgp_pkg::REG_HEAD_GAIN: head_gain_reg   <= cfg_data;
                ddgp_pkg::REG_TURN_GAIN: turn_gain_reg   <= cfg_data;
                ddgp_pkg::REG_SPEED_LIM: speed_limit_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // advance everything when the output register is free or being drained
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // input stage: offsets and half-plane pre-rotation
    logic signed [11:0] dx, dy, adx, ady;
    ddgp_pkg::cordic_t  pre_next;

    always_comb begin
        dx = $signed({1'b0, s_tdata[45:35]}) - $signed({1'b0, s_tdata[14:4]});
        dy = $signed({1'b0, s_tdata[56:46]}) - $signed({1'b0, s_tdata[25:15]});
        adx = (dx < 0) ? -dx : dx;
        ady = (dx < 0) ? -dy : dy;
        pre_next.meta.valid = s_tvalid;
        pre_next.meta.mode  = s_tuser[0];
        pre_next.meta.idx   = s_tdata[3:0];
        pre_next.meta.rh    = s_tdata[34:26];
        pre_next.meta.th    = s_tdata[65:57];
        pre_next.meta.zero  = (dx == 0) && (dy == 0);
        pre_next.x = ddgp_pkg::XY_W'(adx) <<< 8;
        pre_next.y = ddgp_pkg::XY_W'(ady) <<< 8;
        if (dx >= 0)      pre_next.z = '0;
        else if (dy >= 0) pre_next.z = ddgp_pkg::Z_W'(180 * 65536);
        else              pre_next.z = -ddgp_pkg::Z_W'(180 * 65536);
    end

    ddgp_pkg::cordic_t stage [0:CORDIC_STAGES];
    ddgp_pkg::cordic_t pre_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_reg.meta.valid <= 1'b0;
        end else if (en) begin
            pre_reg.meta.valid <= pre_next.meta.valid;
        end
        if (en) begin
            pre_reg.meta.mode <= pre_next.meta.mode;
            pre_reg.meta.idx  <= pre_next.meta.idx;
            pre_reg.meta.rh   <= pre_next.meta.rh;
            pre_reg.meta.th   <= pre_next.meta.th;
            pre_reg.meta.zero <= pre_next.meta.zero;
            pre_reg.x         <= pre_next.x;
            pre_reg.y         <= pre_next.y;
            pre_reg.z         <= pre_next.z;
        end
    end

    assign stage[0] = pre_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        ddgp_cell #(.IDX(i)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .cin     (stage[i]),
            .cout    (stage[i+1])
        );
    end

    logic       o_valid, o_rev, o_clip;
    logic [3:0] o_idx;
    logic [7:0] o_left, o_right;

    ddgp_post #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_post (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .cin         (stage[CORDIC_STAGES]),
        .dist_gain   (dist_gain_reg),
        .head_gain   (head_gain_reg),
        .turn_gain   (turn_gain_reg),
        .speed_limit (speed_limit_reg),
        .out_valid   (o_valid),
        .out_idx     (o_idx),
        .out_left    (o_left),
        .out_right   (o_right),
        .out_rev     (o_rev),
        .out_clip    (o_clip)
    );

    assign m_tvalid = o_valid;
    assign m_tdata  = {4'd0, o_right, o_left, o_idx};
    assign m_tuser  = {o_clip, o_rev};

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output register state");

    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(o_left) <= $signed({1'b0, speed_limit_reg})
                   && $signed(o_left) >= -$signed({1'b0, speed_limit_reg})))
        else $error("left speed beyond limit");

    a_right_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(o_right) <= $signed({1'b0, speed_limit_reg})
                   && $signed(o_right) >= -$signed({1'b0, speed_limit_reg})))
        else $error("right speed beyond limit");

endmodule
`default_nettype wire
